// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the booking checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Labeled assertion on an explicit clock, off while reset is held.
`define IBLO_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block clock and reset.
`define IBLO_ASSERT_CLK(label, prop, msg) \
	`IBLO_ASSERT(label, clk, arst_n, prop, msg)

`endif

// File: sv/iblo_pkg.sv
// ----------------------------------------------------------------------------
// Interval booking package
// Status codes, result and control structs shared by the booking block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iblo_pkg;

	localparam int LIMIT_BITS    = 3;
	localparam int COVER_BITS    = 3;
	localparam int IN_DATA_BITS  = 64;
	localparam int OUT_DATA_BITS = 8;
	localparam int FIELD_BITS    = 32;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 3'd2;

	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_OVER   = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		logic pick;
		logic clr;
		logic acc;
	} cmp_ctl_t;

	typedef struct packed {
		logic    valid;
		logic    accepted;
		status_t status;
	} result_t;

endpackage

`default_nettype wire

// File: sv/interval_booking_overlap_limit.sv
// ----------------------------------------------------------------------------
// Interval booking with overlap limit
// Accepts half-open interval requests and stores those that keep coverage
// within the configured limit.
// ----------------------------------------------------------------------------
// One request is handled at a time; s_tready is low from the transfer of a
// request until its result is loaded into the output register, which can
// hold it while the next request is taken. The test points of a request are
// its start and every stored start lying strictly inside it. Each test point
// is checked by a full pass over the table through its single read port and
// one shared range comparator, and every stored start is fetched at most once
// to find the test points. An overlap rejection ends as soon as the failing
// test point is found. There is no clearing pass after reset; the booking
// count starts at zero and entries are read only below it.
`timescale 1ns / 1ps
`default_nettype none

module interval_booking_overlap_limit #(
	parameter int MAX_BOOKINGS = 64,
	parameter int TIME_BITS    = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// start_time [31:0], end_time [63:32]
	input  wire logic [iblo_pkg::IN_DATA_BITS-1:0]      s_tdata,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// accepted [0], status [2:1], zero [7:3]
	output logic      [iblo_pkg::OUT_DATA_BITS-1:0]     m_tdata,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [iblo_pkg::LIMIT_BITS-1:0]        cfg_data
);

	import iblo_pkg::*;

	localparam int AW = $clog2(MAX_BOOKINGS);

	logic [LIMIT_BITS-1:0]  limit_q;
	logic                   out_valid_q;
	logic                   out_acc_q;
	status_t                out_st_q;
	logic                   out_free;
	result_t                res;
	cmp_ctl_t               cmp_ctl;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [2*TIME_BITS-1:0] rd_data;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [2*TIME_BITS-1:0] wr_data;
	logic [TIME_BITS-1:0]   start_q;
	logic [TIME_BITS-1:0]   end_q;
	logic [TIME_BITS-1:0]   point_q;
	logic                   hit;
	logic [COVER_BITS-1:0]  cover_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(OUT_DATA_BITS - 3){1'b0}}, out_st_q, out_acc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_acc_q <= res.accepted;
			out_st_q  <= res.status;
		end
	end

	iblo_ctrl #(
		.MAX_BOOKINGS(MAX_BOOKINGS),
		.TIME_BITS   (TIME_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.start_in(s_tdata[TIME_BITS-1:0]),
		.end_in  (s_tdata[FIELD_BITS +: TIME_BITS]),
		.limit   (limit_q),
		.out_free(out_free),
		.res     (res),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.cmp_ctl (cmp_ctl),
		.start_q (start_q),
		.end_q   (end_q),
		.point_q (point_q),
		.hit     (hit),
		.cover_q (cover_q)
	);

	iblo_cmp #(
		.TIME_BITS(TIME_BITS)
	) u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cmp_ctl),
		.start_q(start_q),
		.end_q  (end_q),
		.point  (point_q),
		.entry  (rd_data),
		.hit    (hit),
		.cover_q(cover_q)
	);

	iblo_table #(
		.DEPTH(MAX_BOOKINGS),
		.WIDTH(2 * TIME_BITS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule

`default_nettype wire

// File: sv/iblo_table.sv
// ----------------------------------------------------------------------------
// Booking table
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iblo_table #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: sv/iblo_cmp.sv
// ----------------------------------------------------------------------------
// Shared range compare unit
// One range test reused for coverage counting and for picking test points,
// with the saturating coverage counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iblo_cmp #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire iblo_pkg::cmp_ctl_t                ctl,
	input  wire logic [TIME_BITS-1:0]              start_q,
	input  wire logic [TIME_BITS-1:0]              end_q,
	input  wire logic [TIME_BITS-1:0]              point,
	input  wire logic [2*TIME_BITS-1:0]            entry,
	output logic                                   hit,
	output logic      [iblo_pkg::COVER_BITS-1:0]   cover_q
);

	import iblo_pkg::*;

	logic [TIME_BITS-1:0] ent_start;
	logic [TIME_BITS-1:0] ent_end;
	logic [TIME_BITS-1:0] lo;
	logic [TIME_BITS-1:0] x;
	logic [TIME_BITS-1:0] hi;
	logic                 lo_ok;

	assign ent_start = entry[2*TIME_BITS-1:TIME_BITS];
	assign ent_end   = entry[TIME_BITS-1:0];

	// Pick mode asks whether a stored start lies strictly inside the request;
	// count mode asks whether a stored booking covers the current point.
	always_comb begin
		lo    = ctl.pick ? start_q : ent_start;
		x     = ctl.pick ? ent_start : point;
		hi    = ctl.pick ? end_q : ent_end;
		lo_ok = ctl.pick ? (lo < x) : (lo <= x);
		hit   = lo_ok && (x < hi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cover_q <= '0;
		end else if (ctl.clr) begin
			cover_q <= '0;
		end else if (ctl.acc && hit && (cover_q != '1)) begin
			cover_q <= cover_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: sv/iblo_ctrl.sv
// ----------------------------------------------------------------------------
// Booking sequencer
// Walks the test points of a request and scans the table for each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iblo_ctrl #(
	parameter int MAX_BOOKINGS = 64,
	parameter int TIME_BITS    = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [TIME_BITS-1:0]                  start_in,
	input  wire logic [TIME_BITS-1:0]                  end_in,
	input  wire logic [iblo_pkg::LIMIT_BITS-1:0]       limit,
	input  wire logic                                  out_free,
	output iblo_pkg::result_t                          res,
	output logic                                       rd_en,
	output logic      [$clog2(MAX_BOOKINGS)-1:0]       rd_addr,
	input  wire logic [2*TIME_BITS-1:0]                rd_data,
	output logic                                       wr_en,
	output logic      [$clog2(MAX_BOOKINGS)-1:0]       wr_addr,
	output logic      [2*TIME_BITS-1:0]                wr_data,
	output iblo_pkg::cmp_ctl_t                         cmp_ctl,
	output logic      [TIME_BITS-1:0]                  start_q,
	output logic      [TIME_BITS-1:0]                  end_q,
	output logic      [TIME_BITS-1:0]                  point_q,
	input  wire logic                                  hit,
	input  wire logic [iblo_pkg::COVER_BITS-1:0]       cover_q
);

	import iblo_pkg::*;

	localparam int AW = $clog2(MAX_BOOKINGS);
	localparam int CW = $clog2(MAX_BOOKINGS + 1);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SCAN   = 8'b0000_0010,
		S_DRAIN  = 8'b0000_0100,
		S_EVAL   = 8'b0000_1000,
		S_FETCH  = 8'b0001_0000,
		S_PICK   = 8'b0010_0000,
		S_DECIDE = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   cand_q;
	logic [AW-1:0]   idx_q;
	logic [CW-1:0]   count_m1;
	logic            scan_vld_s1;
	logic            res_acc_q;
	status_t         res_st_q;
	logic            full;
	logic            last_idx;

	assign count_m1 = count_q - 1'b1;
	assign last_idx = (idx_q == count_m1[AW-1:0]);
	assign full     = (count_q == CW'(MAX_BOOKINGS));

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		rd_en   = state_q inside {S_SCAN, S_FETCH};
		rd_addr = (state_q == S_SCAN) ? idx_q : cand_q[AW-1:0];
		wr_en   = (state_q == S_DECIDE) && !full;
		wr_addr = count_q[AW-1:0];
		wr_data = {start_q, end_q};

		cmp_ctl.pick = (state_q == S_PICK);
		cmp_ctl.clr  = ((state_q == S_IDLE) && in_valid) || ((state_q == S_PICK) && hit);
		cmp_ctl.acc  = scan_vld_s1;

		res.valid    = (state_q == S_DONE) && out_free;
		res.accepted = res_acc_q;
		res.status   = res_st_q;
	end

	// Read data is registered, so the scan result of an entry is counted in the
	// cycle after it was addressed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == S_SCAN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			cand_q    <= '0;
			idx_q     <= '0;
			res_acc_q <= 1'b0;
			res_st_q  <= ST_STORED;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cand_q <= '0;
						idx_q  <= '0;
						if (start_in > end_in) begin
							res_acc_q <= 1'b0;
							res_st_q  <= ST_EMPTY;
							state_q   <= S_DONE;
						end else if (start_in == end_in) begin
							res_acc_q <= 1'b1;
							res_st_q  <= ST_EMPTY;
							state_q   <= S_DONE;
						end else if (count_q == '0) begin
							state_q <= S_EVAL;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (last_idx) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (cover_q >= limit) begin
						res_acc_q <= 1'b0;
						res_st_q  <= ST_OVER;
						state_q   <= S_DONE;
					end else if (cand_q == count_q) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					cand_q  <= cand_q + 1'b1;
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (hit) begin
						idx_q   <= '0;
						state_q <= S_SCAN;
					end else if (cand_q == count_q) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_DECIDE: begin
					if (full) begin
						res_acc_q <= 1'b0;
						res_st_q  <= ST_FULL;
					end else begin
						count_q   <= count_q + 1'b1;
						res_acc_q <= 1'b1;
						res_st_q  <= ST_STORED;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request bounds and the point under test.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			start_q <= start_in;
			end_q   <= end_in;
			point_q <= start_in;
		end else if ((state_q == S_PICK) && hit) begin
			point_q <= rd_data[2*TIME_BITS-1:TIME_BITS];
		end
	end

endmodule

`default_nettype wire

// File: sv/iblo_checker.sv
// ----------------------------------------------------------------------------
// Booking port checker
// Port-level checks on the booking block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module iblo_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                s_tvalid,
	input wire logic                                s_tready,
	input wire logic [iblo_pkg::IN_DATA_BITS-1:0]   s_tdata,
	input wire logic                                m_tvalid,
	input wire logic                                m_tready,
	input wire logic [iblo_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	input wire logic                                cfg_valid,
	input wire logic                                cfg_ready,
	input wire logic [iblo_pkg::LIMIT_BITS-1:0]     cfg_data
);

	import iblo_pkg::*;

	// A stalled result must stay put.
	`IBLO_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

	// Only one request is in work, so the input closes right after a transfer.
	`IBLO_ASSERT_CLK(a_one_in_work, s_tvalid && s_tready |=> !s_tready, "input open while a request is in work")

	// A new result only shows up at the end of a request's work.
	`IBLO_ASSERT_CLK(a_result_from_work, $rose(m_tvalid) |-> !$past(s_tready), "result without a request in work")

	// Overlap and full rejections never report acceptance.
	`IBLO_ASSERT_CLK(a_reject_flag, m_tvalid && (m_tdata[2:1] == ST_OVER || m_tdata[2:1] == ST_FULL) |-> !m_tdata[0], "rejection marked accepted")

endmodule

bind interval_booking_overlap_limit iblo_checker u_iblo_checker (.*);

`default_nettype wire

// File: test/tb_interval_booking_overlap_limit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval booking overlap limit testbench
// Sends booking requests over the input stream and limit writes over the
// configuration channel. Each decision is predicted from a private table of
// accepted bookings and compared, in order, with every result transfer.
// ----------------------------------------------------------------------------
module tb_interval_booking_overlap_limit;
	import iblo_pkg::*;

	localparam int MAX_BOOKINGS = 64;
	localparam int TIME_BITS = 32;
	localparam int PHASE_COUNT = 6;
	localparam int PHASE_ITEMS = 150;
	localparam int HOLD_OFF_CYCLES = 5000;
	localparam int DRAIN_CYCLES = 5000;
	localparam longint unsigned CYCLE_LIMIT = 20_000_000;
	// Limit used in each random phase, phase 0 in the lowest bits.
	localparam logic [PHASE_COUNT*LIMIT_BITS-1:0] PHASE_LIMITS =
		{3'd7, 3'd5, 3'd2, 3'd4, 3'd1, 3'd7};
	localparam int DIRECTED_COUNT = 21;

	typedef logic [TIME_BITS-1:0] stamp_t;

	typedef struct packed {
		logic    accepted;
		status_t status;
	} decision_t;

	typedef enum bit {ROW_REQUEST, ROW_LIMIT} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [LIMIT_BITS-1:0] limit;
		stamp_t                start_time;
		stamp_t                end_time;
		bit                    known;
		decision_t             decision;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// start_time [31:0], end_time [63:32]
	logic [IN_DATA_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// accepted [0], status [2:1], zero [7:3]
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LIMIT_BITS-1:0] cfg_data = '0;

	stamp_t booked_start[$];
	stamp_t booked_end[$];
	logic [LIMIT_BITS-1:0] limit_now = LIMIT_RESET;
	decision_t decisions_due[$];
	directed_row_t directed_rows [DIRECTED_COUNT];
	int unsigned error_count = 0;
	bit idling = 1'b1;
	logic hold_off_wanted = 1'b0;
	longint unsigned cycle_count = 0;

	interval_booking_overlap_limit #(
		.MAX_BOOKINGS(MAX_BOOKINGS),
		.TIME_BITS(TIME_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int unsigned bookings_covering(stamp_t point);
		int unsigned n = 0;
		foreach (booked_start[i])
			if (booked_start[i] <= point && point < booked_end[i])
				n++;
		return n;
	endfunction

	// The deepest coverage inside a new interval is at its own start or at a
	// stored start that lies strictly inside it.
	function automatic decision_t decide_booking(stamp_t s, stamp_t e);
		bit over;
		if (s > e)
			return '{1'b0, ST_EMPTY};
		if (s == e)
			return '{1'b1, ST_EMPTY};
		over = (bookings_covering(s) + 1 > limit_now);
		foreach (booked_start[i])
			if (booked_start[i] > s && booked_start[i] < e &&
			    bookings_covering(booked_start[i]) + 1 > limit_now)
				over = 1'b1;
		if (over)
			return '{1'b0, ST_OVER};
		if (booked_start.size() >= MAX_BOOKINGS)
			return '{1'b0, ST_FULL};
		booked_start.push_back(s);
		booked_end.push_back(e);
		return '{1'b1, ST_STORED};
	endfunction

	task automatic offer_booking(input stamp_t s, input stamp_t e, input bit known,
			input decision_t typed);
		decision_t predicted;
		if (idling && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {e, s};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = decide_booking(s, e);
		decisions_due.push_back(known ? typed : predicted);
	endtask

	// The limit only changes while nothing is in flight.
	task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
		s_tvalid <= 1'b0;
		while (decisions_due.size() != 0)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		limit_now = value;
	endtask

	always @(posedge clk) begin
		decision_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (decisions_due.size() == 0) begin
				$error("result transfer with nothing expected, m_tdata %h", m_tdata);
				error_count++;
			end else begin
				want = decisions_due.pop_front();
				if (m_tdata[0] !== want.accepted) begin
					$error("accepted: expected %0d, actual %0d", want.accepted, m_tdata[0]);
					error_count++;
				end
				if (m_tdata[2:1] !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tdata[2:1]);
					error_count++;
				end
				if (m_tdata[7:3] !== '0) begin
					$error("pad: expected 0, actual %0d", m_tdata[7:3]);
					error_count++;
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_off_wanted) begin
				// Long hold-off so the output register and the input side fill up.
				hold_off_wanted <= 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (idling && $urandom_range(0, 15) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		directed_row_t row;
		stamp_t base;
		stamp_t s;
		stamp_t e;
		int unsigned pick;

		directed_rows = '{
			'{ROW_REQUEST, 3'd0, 32'd5, 32'd5, 1'b1, '{1'b1, ST_EMPTY}},
			'{ROW_REQUEST, 3'd0, 32'd9, 32'd3, 1'b1, '{1'b0, ST_EMPTY}},
			'{ROW_REQUEST, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, ST_EMPTY}},
			'{ROW_REQUEST, 3'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, '{1'b0, ST_EMPTY}},
			'{ROW_REQUEST, 3'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, '{1'b1, ST_STORED}},
			'{ROW_REQUEST, 3'd0, 32'd100, 32'd200, 1'b0, '{1'b0, ST_STORED}},
			'{ROW_REQUEST, 3'd0, 32'd150, 32'd160, 1'b0, '{1'b0, ST_STORED}},
			'{ROW_REQUEST, 3'd0, 32'd200, 32'd300, 1'b0, '{1'b0, ST_STORED}},
			'{ROW_REQUEST, 3'd0, 32'd50, 32'd150, 1'b0, '{1'b0, ST_STORED}},
			'{ROW_REQUEST, 3'd0, 32'd199, 32'd201, 1'b0, '{1'b0, ST_STORED}},
			'{ROW_LIMIT, 3'd1, 32'd0, 32'd0, 1'b0, '{1'b0, ST_STORED}},
			'{ROW_REQUEST, 3'd0, 32'h8000_0000, 32'h8000_0001, 1'b0, '{1'b0, ST_STORED}},
			'{ROW_LIMIT, 3'd0, 32'd0, 32'd0, 1'b0, '{1'b0, ST_STORED}},
			'{ROW_REQUEST, 3'd0, 32'd1, 32'd2, 1'b1, '{1'b0, ST_OVER}},
			'{ROW_REQUEST, 3'd0, 32'd7, 32'd7, 1'b1, '{1'b1, ST_EMPTY}},
			'{ROW_REQUEST, 3'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, '{1'b0, ST_OVER}},
			'{ROW_LIMIT, 3'd7, 32'd0, 32'd0, 1'b0, '{1'b0, ST_STORED}},
			'{ROW_REQUEST, 3'd0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, '{1'b0, ST_STORED}},
			'{ROW_REQUEST, 3'd0, 32'd0, 32'd1, 1'b0, '{1'b0, ST_STORED}},
			'{ROW_REQUEST, 3'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, '{1'b0, ST_STORED}},
			'{ROW_REQUEST, 3'd0, 32'd100, 32'd101, 1'b0, '{1'b0, ST_STORED}}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_LIMIT)
				write_limit(row.limit);
			else
				offer_booking(row.start_time, row.end_time, row.known, row.decision);
		end

		// Requests mostly fall into one narrow window so that bookings overlap
		// and the table fills; a few span the whole time range.
		base = $urandom_range(0, 32'hFFFF_FE00);
		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_limit(PHASE_LIMITS[p*LIMIT_BITS +: LIMIT_BITS]);
			idling = (p != 2 && p != PHASE_COUNT - 1);
			if (p == 3)
				hold_off_wanted <= 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				s = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FE00 : base;
				s = s + $urandom_range(0, 255);
				if (pick < 6) begin
					s = $urandom;
					e = $urandom;
				end else if (pick < 10) begin
					e = s;
				end else if (pick < 14) begin
					e = s;
					s = s + $urandom_range(1, 16);
				end else begin
					e = s + $urandom_range(1, 24);
				end
				offer_booking(s, e, 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (decisions_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
